[rtl/core/arpc_pkg.sv]
`default_nettype none

package arpc_pkg;

  localparam int ENTRIES   = 16;
  localparam int TIME_BITS = 32;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int MAC_W     = 48;
  localparam int IP_W      = 32;
  localparam int NOW_W     = 32;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DEL      = 2'd1,
    OP_LOOK_MAC = 2'd2,
    OP_LOOK_IP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    time_t            stamp;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             apply;
    op_e              op;
    logic             use_mac;
    logic             append;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    time_t            stamp;
  } cell_cmd_t;

  // Handed from each cell to the next one up the chain.
  typedef struct packed {
    logic mac_seen;
    logic ip_seen;
    logic past;
  } cell_link_t;

  function automatic time_t to_time(logic [NOW_W-1:0] now);
    logic [63:0] w;
    w = {32'd0, now};
    return w[TIME_BITS-1:0];
  endfunction

  function automatic logic [NOW_W-1:0] from_time(time_t t);
    logic [63:0] w;
    w = 64'(t);
    return w[NOW_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/arpc_cell.sv]
`default_nettype none

module arpc_cell import arpc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             cap_i,
  input  wire logic [MAC_W-1:0] key_mac_i,
  input  wire logic [IP_W-1:0]  key_ip_i,
  input  wire logic             valid_i,
  input  wire logic             tail_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire cell_link_t       link_i,
  output      cell_link_t       link_o,
  input  wire entry_t           next_i,
  output      entry_t           entry_o,
  output      logic             sel_o
);

  entry_t entry_q, entry_d;
  logic   mac_hit_q, ip_hit_q;
  logic   first_mac, first_ip;

  // Compare against the incoming key while the word is accepted.
  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      mac_hit_q <= valid_i && (entry_q.mac == key_mac_i);
      ip_hit_q  <= valid_i && (entry_q.ip == key_ip_i);
    end
    entry_q <= entry_d;
  end

  always_comb begin
    first_mac       = mac_hit_q && !link_i.mac_seen;
    first_ip        = ip_hit_q && !link_i.ip_seen;
    sel_o           = cmd_i.use_mac ? first_mac : first_ip;
    link_o.mac_seen = link_i.mac_seen || mac_hit_q;
    link_o.ip_seen  = link_i.ip_seen || ip_hit_q;
    link_o.past     = link_i.past || sel_o;
  end

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.apply) begin
      unique case (cmd_i.op)
        OP_ADD: begin
          if (sel_o) begin
            if (cmd_i.use_mac) begin
              entry_d.ip = cmd_i.ip;
            end else begin
              entry_d.mac = cmd_i.mac;
            end
            entry_d.stamp = cmd_i.stamp;
          end else if (cmd_i.append && tail_i) begin
            entry_d.mac   = cmd_i.mac;
            entry_d.ip    = cmd_i.ip;
            entry_d.stamp = cmd_i.stamp;
          end
        end
        OP_DEL: begin
          // Shift down from the removed slot onward.
          if (link_o.past) begin
            entry_d = next_i;
          end
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[rtl/core/arp_cache_table.sv]
`default_nettype none

// Ordered ARP cache of ENTRIES slots, each holding a MAC, an IPv4 address and
// an update time, kept oldest first in a chain of cells. A new word is taken
// only once the previous one has been committed: in the accept cycle every
// cell compares its MAC and IPv4 against the key in parallel, and in the
// commit cycle the earliest match is resolved along the cell chain, the
// table is updated (delete shifts the later cells down one place) and the
// result is loaded into the output register. The commit waits while an
// earlier result is still held in the output register. The table is empty
// after reset with no clearing pass; only the entry count is reset.

module arp_cache_table import arpc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [MAC_W-1:0] mac_i,
  input  wire logic [IP_W-1:0]  ipv4_i,
  input  wire logic [NOW_W-1:0] now_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic [1:0]       status_o,
  output      logic [MAC_W-1:0] entry_mac_o,
  output      logic [IP_W-1:0]  entry_ipv4_o,
  output      logic [NOW_W-1:0] entry_time_o
);

  // Control state.
  logic             busy_q, busy_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Held key of the word in flight.
  op_e              op_q;
  logic [MAC_W-1:0] mac_q;
  logic [IP_W-1:0]  ip_q;
  logic [NOW_W-1:0] now_q;

  // Result register.
  status_e          status_q, status_d;
  logic [MAC_W-1:0] res_mac_q, res_mac_d;
  logic [IP_W-1:0]  res_ip_q, res_ip_d;
  logic [NOW_W-1:0] res_time_q, res_time_d;

  logic         accept, done;
  logic         any_mac, any_ip, hit, full;
  cell_cmd_t    cmd;
  cell_link_t   link [ENTRIES+1];
  entry_t       entry [ENTRIES];
  entry_t       next [ENTRIES];
  logic [ENTRIES-1:0] sel;
  entry_t       pick;

  // Take a word whenever nothing is in flight; finish once the output is free.
  assign accept     = in_valid_i && !busy_q;
  assign done       = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q;

  assign link[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_last
      assign next[i] = entry[i];
    end else begin : g_mid
      assign next[i] = entry[i+1];
    end

    arpc_cell u_cell (
      .clk_i     (clk_i),
      .cap_i     (accept),
      .key_mac_i (mac_i),
      .key_ip_i  (ipv4_i),
      .valid_i   (CNT_W'(i) < count_q),
      .tail_i    (CNT_W'(i) == count_q),
      .cmd_i     (cmd),
      .link_i    (link[i]),
      .link_o    (link[i+1]),
      .next_i    (next[i]),
      .entry_o   (entry[i]),
      .sel_o     (sel[i])
    );
  end

  assign any_mac = link[ENTRIES].mac_seen;
  assign any_ip  = link[ENTRIES].ip_seen;
  assign hit     = link[ENTRIES].past;
  assign full    = (count_q == CNT_W'(ENTRIES));

  // Broadcast command: a lookup matches on its own key only; add and delete
  // prefer a MAC match over an IP match.
  always_comb begin
    cmd.apply   = done;
    cmd.op      = op_q;
    cmd.use_mac = (op_q == OP_LOOK_MAC) || ((op_q != OP_LOOK_IP) && any_mac);
    cmd.append  = (op_q == OP_ADD) && !any_mac && !any_ip && !full;
    cmd.mac     = mac_q;
    cmd.ip      = ip_q;
    cmd.stamp   = to_time(now_q);
  end

  // Select the matched cell's contents; at most one sel bit is set.
  always_comb begin
    pick = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        pick = pick | entry[i];
      end
    end
  end

  always_comb begin
    status_d   = status_q;
    res_mac_d  = res_mac_q;
    res_ip_d   = res_ip_q;
    res_time_d = res_time_q;
    count_d    = count_q;
    if (done) begin
      res_mac_d  = '0;
      res_ip_d   = '0;
      res_time_d = '0;
      if (op_q == OP_ADD) begin
        if (any_mac || any_ip || !full) begin
          // Added or updated entry always equals the key fields.
          status_d   = ST_OK;
          res_mac_d  = mac_q;
          res_ip_d   = ip_q;
          res_time_d = from_time(to_time(now_q));
          if (cmd.append) begin
            count_d = count_q + CNT_W'(1);
          end
        end else begin
          status_d = ST_FULL;
        end
      end else if (hit) begin
        status_d   = ST_OK;
        res_mac_d  = pick.mac;
        res_ip_d   = pick.ip;
        res_time_d = from_time(pick.stamp);
        if (op_q == OP_DEL) begin
          count_d = count_q - CNT_W'(1);
        end
      end else begin
        status_d = ST_MISS;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Hold the key for the commit cycle; hold the result until taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      mac_q <= mac_i;
      ip_q  <= ipv4_i;
      now_q <= now_i;
    end
    status_q   <= status_d;
    res_mac_q  <= res_mac_d;
    res_ip_q   <= res_ip_d;
    res_time_q <= res_time_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign entry_mac_o  = res_mac_q;
  assign entry_ipv4_o = res_ip_q;
  assign entry_time_o = res_time_q;

endmodule

`default_nettype wire

[rtl/core/arpc_checker.sv]
`default_nettype none

module arpc_checker import arpc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [1:0]       status_o,
  input wire logic [MAC_W-1:0] entry_mac_o,
  input wire logic [IP_W-1:0]  entry_ipv4_o,
  input wire logic [NOW_W-1:0] entry_time_o
);

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(entry_mac_o) && $stable(entry_ipv4_o) && $stable(entry_time_o))
    else $error("result changed while stalled");

  // Status never takes the unused code.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("illegal status");

  // Miss and full results carry zero fields.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
    entry_mac_o == '0 && entry_ipv4_o == '0 && entry_time_o == '0)
    else $error("non-zero fields on miss or full");

  // An accepted word blocks input until its result has been produced.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while busy");

  // The result of an accepted word shows up once the output is free.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing after accept");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (.*);

`default_nettype wire
